@@ src/clm_pkg.sv @@
// types, constants and helpers shared by the cohort ticket lock manager
`default_nettype none

package clm_pkg;

  localparam int NODES            = 4;
  localparam int GRANT_SLOT_COUNT = 2;
  localparam int TICKET_BITS      = 16;

  // node field is two bits wide, which indexes up to four nodes
  localparam int NODE_W  = 2;
  localparam int VISIT_W = 10;
  localparam int SLOT_W  = (GRANT_SLOT_COUNT > 1) ? $clog2(GRANT_SLOT_COUNT) : 1;

  localparam logic [VISIT_W-1:0] VISIT_RESET = 10'd64;
  localparam logic [VISIT_W-1:0] VISIT_MAX   = 10'd1023;

  typedef logic [TICKET_BITS-1:0] ticket_t;
  typedef logic [NODE_W-1:0]      node_t;
  typedef logic [VISIT_W-1:0]     visit_t;
  typedef logic [SLOT_W-1:0]      slot_t;

  typedef enum logic [1:0] {
    KIND_QUEUED   = 2'd0,
    KIND_GRANTED  = 2'd1,
    KIND_RELEASED = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_GLOBAL = 2'd1,
    MODE_LOCAL  = 2'd2,
    MODE_BUSY   = 2'd3
  } mode_t;

  typedef enum logic {
    FUNC_ACQUIRE = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EXEC,
    B_SCAN,
    B_HEAD,
    B_OUT1,
    B_OUT2
  } back_state_t;

  // classified item as it travels from front to back
  typedef struct packed {
    func_t func;
    node_t node;
    logic  bad_node;
  } item_t;

  typedef struct packed {
    kind_t   kind;
    node_t   node;
    ticket_t ticket;
    logic    passed;
  } result_t;

  // grant slot that a global ticket maps to; the slot count is a power of two
  function automatic slot_t slot_of(input ticket_t t);
    return SLOT_W'(t & ticket_t'(GRANT_SLOT_COUNT - 1));
  endfunction

endpackage

`default_nettype wire

@@ src/clm_ifs.sv @@
// valid/ready channel interfaces for requests, results and configuration
`default_nettype none

interface clm_in_if import clm_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  func;
  node_t node;

  modport source (output valid, output func, output node, input ready);
  modport sink   (input valid, input func, input node, output ready);
endinterface

interface clm_out_if import clm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  node_t       node_res;
  ticket_t     ticket;
  logic        passed_locally;
  logic        last;

  modport source (output valid, output kind, output node_res, output ticket,
                  output passed_locally, output last, input ready);
  modport sink   (input valid, input kind, input node_res, input ticket,
                  input passed_locally, input last, output ready);
endinterface

interface clm_cfg_if import clm_pkg::*; ();
  logic   valid;
  logic   ready;
  visit_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/clm_front.sv @@
// front end: takes requests, classifies them and queues them for the back end
`default_nettype none

module clm_front import clm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  clm_in_if.sink req,
  output logic   q_valid,
  output item_t  q_item,
  input  logic   q_pop
);

  item_t      fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      incoming;

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;

  always_comb begin
    incoming.func     = func_t'(req.func);
    incoming.node     = req.node;
    incoming.bad_node = ({1'b0, req.node} >= (NODE_W+1)'(NODES));
  end

  assign q_valid = (count != 2'd0);
  assign q_item  = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= incoming;
  end

endmodule

`default_nettype wire

@@ src/clm_back.sv @@
// back end: per-node lock state and the sequencer that carries out each event
`default_nettype none

module clm_back import clm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  clm_cfg_if.sink    cfg,
  clm_out_if.source  res
);

  back_state_t state, state_next;

  visit_t  visit_limit;
  ticket_t next_tk   [NODES];
  ticket_t serving   [NODES];
  visit_t  visit     [NODES];
  mode_t   mode      [NODES];
  ticket_t held      [NODES];
  logic    awaiting  [NODES];
  ticket_t gnext;
  ticket_t slot_grant [GRANT_SLOT_COUNT];

  item_t   cur;
  result_t res1;
  result_t res2;
  logic    has2;

  node_t   n;
  ticket_t me;
  ticket_t nx;
  logic    full;
  logic    at_head;
  logic    rel_bad;
  ticket_t cur_srv;
  logic    alone;
  logic    passed;
  ticket_t nt;
  logic    cand [NODES];
  logic    found;
  node_t   fm;
  logic    head_local;
  logic    g_hit;
  logic    head_grant;
  logic    do_head;
  logic    out_free;
  logic    out_load;

  assign cfg.ready = 1'b1;
  assign out_free  = !res.valid || res.ready;

  // event decode against the current node state
  always_comb begin
    n          = cur.node;
    me         = next_tk[n];
    nx         = me + 1'b1;
    full       = (nx == serving[n]);
    at_head    = (me == serving[n]);
    rel_bad    = (mode[n] != MODE_BUSY) || awaiting[n];
    cur_srv    = serving[n];
    alone      = ((next_tk[n] - 1'b1) == cur_srv);
    passed     = !(alone || (visit[n] >= visit_limit));
    nt         = held[n] + 1'b1;
    head_local = (mode[n] == MODE_LOCAL);
    g_hit      = (slot_grant[slot_of(gnext)] == gnext);
    head_grant = head_local || g_hit;
    do_head    = (cur.func == FUNC_ACQUIRE) || (serving[n] != next_tk[n]);
  end

  // waiting heads of other nodes whose global ticket is now served
  always_comb begin
    for (int m = 0; m < NODES; m++) begin
      cand[m] = (NODE_W'(m) != n) && awaiting[m] &&
                (slot_grant[slot_of(held[m])] == held[m]);
    end
  end

  always_comb begin
    found = 1'b0;
    fm    = '0;
    for (int m = 0; m < NODES; m++) begin
      if (!found && cand[m]) begin
        found = 1'b1;
        fm    = NODE_W'(m);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    case (state)
      B_IDLE: begin
        q_pop = q_valid;
        if (q_valid) state_next = B_EXEC;
      end
      B_EXEC: begin
        if (cur.bad_node) begin
          state_next = B_OUT1;
        end else if (cur.func == FUNC_ACQUIRE) begin
          state_next = (!full && at_head) ? B_HEAD : B_OUT1;
        end else if (rel_bad) begin
          state_next = B_OUT1;
        end else begin
          state_next = passed ? B_HEAD : B_SCAN;
        end
      end
      B_SCAN: state_next = B_HEAD;
      B_HEAD: state_next = B_OUT1;
      B_OUT1: begin
        out_load = out_free;
        if (out_free) state_next = has2 ? B_OUT2 : B_IDLE;
      end
      B_OUT2: begin
        out_load = out_free;
        if (out_free) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // lock state and control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      visit_limit <= VISIT_RESET;
      gnext       <= '0;
      has2        <= 1'b0;
      res.valid   <= 1'b0;
      for (int i = 0; i < NODES; i++) begin
        next_tk[i]  <= '0;
        serving[i]  <= '0;
        visit[i]    <= '0;
        mode[i]     <= MODE_GLOBAL;
        held[i]     <= '0;
        awaiting[i] <= 1'b0;
      end
      for (int s = 0; s < GRANT_SLOT_COUNT; s++) slot_grant[s] <= '0;
    end else begin
      if (cfg.valid) visit_limit <= cfg.data;

      if (out_load)       res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;

      case (state)
        B_EXEC: begin
          has2 <= 1'b0;
          if (!cur.bad_node) begin
            if (cur.func == FUNC_ACQUIRE) begin
              if (!full) next_tk[n] <= nx;
            end else if (!rel_bad) begin
              if (!passed) begin
                mode[n]                <= MODE_GLOBAL;
                slot_grant[slot_of(nt)] <= nt;
              end else begin
                mode[n] <= MODE_LOCAL;
              end
              serving[n] <= cur_srv + 1'b1;
            end
          end
        end
        B_SCAN: begin
          if (found) begin
            awaiting[fm] <= 1'b0;
            visit[fm]    <= '0;
            mode[fm]     <= MODE_BUSY;
            has2         <= 1'b1;
          end
        end
        B_HEAD: begin
          if (do_head) begin
            if (head_local) begin
              if (visit[n] != VISIT_MAX) visit[n] <= visit[n] + 1'b1;
              mode[n] <= MODE_BUSY;
            end else begin
              held[n] <= gnext;
              gnext   <= gnext + 1'b1;
              if (g_hit) begin
                awaiting[n] <= 1'b0;
                visit[n]    <= '0;
                mode[n]     <= MODE_BUSY;
              end else begin
                awaiting[n] <= 1'b1;
                mode[n]     <= MODE_GLOBAL;
              end
            end
            if (cur.func == FUNC_RELEASE && head_grant) has2 <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // item, pending results and output payload
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_valid) cur <= q_item;
      end
      B_EXEC: begin
        res1.node   <= cur.node;
        res1.passed <= 1'b0;
        res1.kind   <= KIND_ERROR;
        res1.ticket <= '0;
        if (!cur.bad_node) begin
          if (cur.func == FUNC_ACQUIRE) begin
            if (!full) begin
              res1.kind   <= KIND_QUEUED;
              res1.ticket <= me;
            end
          end else if (!rel_bad) begin
            res1.kind   <= KIND_RELEASED;
            res1.ticket <= cur_srv;
            res1.passed <= passed;
          end
        end
      end
      B_SCAN: begin
        if (found) begin
          res2.kind   <= KIND_GRANTED;
          res2.node   <= fm;
          res2.ticket <= serving[fm];
          res2.passed <= 1'b0;
        end
      end
      B_HEAD: begin
        if (cur.func == FUNC_ACQUIRE) begin
          res1.kind <= head_grant ? KIND_GRANTED : KIND_QUEUED;
        end else if (do_head && head_grant && !has2) begin
          res2.kind   <= KIND_GRANTED;
          res2.node   <= n;
          res2.ticket <= serving[n];
          res2.passed <= 1'b0;
        end
      end
      B_OUT1: begin
        if (out_free) begin
          res.kind           <= res1.kind;
          res.node_res       <= res1.node;
          res.ticket         <= res1.ticket;
          res.passed_locally <= res1.passed;
          res.last           <= !has2;
        end
      end
      B_OUT2: begin
        if (out_free) begin
          res.kind           <= res2.kind;
          res.node_res       <= res2.node;
          res.ticket         <= res2.ticket;
          res.passed_locally <= res2.passed;
          res.last           <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ src/cohort_ticket_lock_manager_top.sv @@
// top level of the cohort ticket lock manager
`default_nettype none

// cohort ticket lock manager: each request transfer on req is an acquire or a
// release from one node; each produces one or two result transfers on res
// (queued, granted, release done or error), the final one marked by last.
// a front end classifies requests into a two-entry queue so the requester can
// keep transferring while the back end works; the back end handles one event
// at a time with a step sequencer over the per-node ticket, mode and visit
// registers; its steps are fetch, execute, waiter scan, new head and a step
// per result. queued acquires and errors skip the scan and new head, and
// new local heads from acquires and locally passing releases skip the scan.
// results leave through a registered output stage, so a stalled consumer holds
// the back end but not the front queue. visit_limit resets to 64 and is
// written through cfg, always ready; the user writes it only while the block
// is idle, which it does not enforce. lock and control state reset on rst
// synchronously with no clearing pass; item and result payloads do not reset

module cohort_ticket_lock_manager_top import clm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  clm_in_if.sink    req,
  clm_out_if.source res,
  clm_cfg_if.sink   cfg
);

  // queue head between front and back
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // request classification and queueing
  clm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // lock state, event sequencing and result output
  clm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .res     (res)
  );

endmodule

`default_nettype wire

@@ sim/lock_grant_checker.sv @@
// lock event predictor and result comparison for the cohort ticket lock manager
`timescale 1ns / 1ps

module lock_grant_checker import clm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  clm_in_if                req,
  clm_out_if               res,
  clm_cfg_if               cfg,
  output int unsigned      fail_count,
  output int unsigned      pending,
  output logic [NODES-1:0] busy_nodes
);

  typedef struct {
    kind_t   kind;
    node_t   node;
    ticket_t ticket;
    logic    passed;
    logic    last;
  } lock_event_t;

  lock_event_t awaited[$];

  visit_t  handoff_limit;
  ticket_t next_tkt[NODES];
  ticket_t serving_tkt[NODES];
  ticket_t global_tkt[NODES];
  visit_t  visits[NODES];
  mode_t   mode[NODES];
  logic    wants_global[NODES];
  ticket_t global_next;
  ticket_t slot_owner[GRANT_SLOT_COUNT];

  int unsigned faults;
  int unsigned seen;

  function automatic lock_event_t ev(kind_t k, node_t n, ticket_t t, logic p);
    lock_event_t e;
    e.kind   = k;
    e.node   = n;
    e.ticket = t;
    e.passed = p;
    e.last   = 1'b0;
    return e;
  endfunction

  // waiting head takes the lock once its grant slot shows its ticket
  function automatic bit global_turn(int n);
    ticket_t t;
    t = global_tkt[n];
    if (!wants_global[n]) return 1'b0;
    if (slot_owner[int'(t) % GRANT_SLOT_COUNT] != t) return 1'b0;
    wants_global[n] = 1'b0;
    visits[n]       = '0;
    mode[n]         = MODE_BUSY;
    return 1'b1;
  endfunction

  // new local head: inherit from a local handoff or draw a global ticket
  function automatic bit new_head(int n);
    if (mode[n] == MODE_LOCAL) begin
      if (visits[n] != VISIT_MAX) visits[n] = visits[n] + 1'b1;
      mode[n] = MODE_BUSY;
      return 1'b1;
    end
    mode[n]         = MODE_GLOBAL;
    global_tkt[n]   = global_next;
    global_next     = global_next + 1'b1;
    wants_global[n] = 1'b1;
    return global_turn(n);
  endfunction

  function automatic void predict_lock_step(func_t f, node_t nd);
    lock_event_t fresh[2];
    int          k, n, m, i;
    ticket_t     mine, cur, nt;
    bit          alone, keep, hit;
    k   = 0;
    n   = int'(nd);
    hit = 1'b0;
    if (n >= NODES) begin
      fresh[0] = ev(KIND_ERROR, nd, '0, 1'b0);
      k = 1;
    end else if (f == FUNC_ACQUIRE) begin
      mine = next_tkt[n];
      if (ticket_t'(mine + 1'b1) == serving_tkt[n]) begin
        fresh[0] = ev(KIND_ERROR, nd, '0, 1'b0);
      end else begin
        next_tkt[n] = mine + 1'b1;
        if (mine == serving_tkt[n]) hit = new_head(n);
        fresh[0] = ev(hit ? KIND_GRANTED : KIND_QUEUED, nd, mine, 1'b0);
      end
      k = 1;
    end else if (mode[n] != MODE_BUSY || wants_global[n]) begin
      fresh[0] = ev(KIND_ERROR, nd, '0, 1'b0);
      k = 1;
    end else begin
      cur   = serving_tkt[n];
      alone = (ticket_t'(next_tkt[n] - 1'b1) == cur);
      keep  = !(alone || visits[n] >= handoff_limit);
      if (!keep) begin
        nt = global_tkt[n] + 1'b1;
        mode[n] = MODE_GLOBAL;
        slot_owner[int'(nt) % GRANT_SLOT_COUNT] = nt;
      end else begin
        mode[n] = MODE_LOCAL;
      end
      serving_tkt[n] = cur + 1'b1;
      fresh[0] = ev(KIND_RELEASED, nd, cur, keep);
      k = 1;
      // lock went back to the global queue: first waiting head in node order
      if (!keep) begin
        for (m = 0; m < NODES; m++) begin
          if (!hit && m != n) begin
            if (global_turn(m)) begin
              fresh[k] = ev(KIND_GRANTED, node_t'(m), serving_tkt[m], 1'b0);
              k++;
              hit = 1'b1;
            end
          end
        end
      end
      if (serving_tkt[n] != next_tkt[n]) begin
        if (new_head(n) && k < 2) begin
          fresh[k] = ev(KIND_GRANTED, nd, serving_tkt[n], 1'b0);
          k++;
        end
      end
    end
    fresh[k-1].last = 1'b1;
    for (i = 0; i < k; i++) awaited.push_back(fresh[i]);
  endfunction

  task automatic report(string what);
    faults++;
    if (faults <= 40) $display("%0t ns lock check: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    lock_event_t      want;
    string            diff;
    logic [NODES-1:0] mask;
    int               i;
    if (rst) begin
      handoff_limit = VISIT_RESET;
      for (i = 0; i < NODES; i++) begin
        next_tkt[i]     = '0;
        serving_tkt[i]  = '0;
        global_tkt[i]   = '0;
        visits[i]       = '0;
        mode[i]         = MODE_GLOBAL;
        wants_global[i] = 1'b0;
      end
      global_next = '0;
      for (i = 0; i < GRANT_SLOT_COUNT; i++) slot_owner[i] = '0;
      awaited.delete();
      faults = 0;
      seen   = 0;
    end else begin
      // results first: a request transferred on this edge cannot cause one yet
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        seen++;
        if (awaited.size() == 0) begin
          report($sformatf("result %0d arrived with nothing awaited (kind %0d node %0d)",
                           seen, res.kind, res.node_res));
        end else begin
          want = awaited.pop_front();
          diff = "";
          if (res.kind !== want.kind)             diff = {diff, " kind"};
          if (res.node_res !== want.node)         diff = {diff, " node"};
          if (res.ticket !== want.ticket)         diff = {diff, " ticket"};
          if (res.passed_locally !== want.passed) diff = {diff, " passed"};
          if (res.last !== want.last)             diff = {diff, " last"};
          if (diff != "")
            report($sformatf({"result %0d wrong in%s: got %0d/%0d/%0d/%0b/%0b,",
                              " wanted %0d/%0d/%0d/%0b/%0b"}, seen, diff,
                             res.kind, res.node_res, res.ticket, res.passed_locally,
                             res.last, want.kind, want.node, want.ticket, want.passed,
                             want.last));
        end
      end
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) handoff_limit = cfg.data;
      if (req.valid === 1'b1 && req.ready === 1'b1)
        predict_lock_step(func_t'(req.func), req.node);
    end
    for (i = 0; i < NODES; i++) mask[i] = (mode[i] == MODE_BUSY) && !wants_global[i];
    busy_nodes <= mask;
    pending    <= awaited.size();
    fail_count <= faults;
  end

endmodule

@@ sim/tb_top.sv @@
// top of the cohort ticket lock manager testbench: stimulus, clocking and verdict
`timescale 1ns / 1ps

module tb_top;
  import clm_pkg::*;

  // generous bound: several times a run with the longest gaps and stalls
  localparam int unsigned CYCLE_LIMIT = 600_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  clm_in_if  req_if ();
  clm_out_if res_if ();
  clm_cfg_if cfg_if ();

  int unsigned      mismatches;
  int unsigned      awaited_count;
  logic [NODES-1:0] busy_nodes;
  int unsigned      cycles = 0;
  // no idling on either side while set
  bit               quiet = 1'b0;

  cohort_ticket_lock_manager_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  lock_grant_checker lock_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .res        (res_if),
    .cfg        (cfg_if),
    .fail_count (mismatches),
    .pending    (awaited_count),
    .busy_nodes (busy_nodes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[cohort_ticket_lock_manager_top] ERROR");
      $finish;
    end
  end

  function automatic int idle_draw();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  // result side: random stall before each transfer, ready held until it happens
  initial begin : result_sink
    int stall;
    res_if.ready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (res_if.valid !== 1'b1);
    end
  end

  // valid stays high from one request to the next unless a gap is drawn
  task automatic hold_off(int n);
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic push_req(func_t f, node_t n);
    req_if.valid <= 1'b1;
    req_if.func  <= f;
    req_if.node  <= n;
    do @(posedge clk); while (req_if.ready !== 1'b1);
  endtask

  task automatic step_req(func_t f, int n);
    hold_off(idle_draw());
    push_req(f, node_t'(n));
  endtask

  // sender holds off until every awaited result has been transferred;
  // the counter is registered, hence the first wait
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(visit_t v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic burst(func_t f, int n, int count);
    int i;
    for (i = 0; i < count; i++) push_req(f, node_t'(n));
  endtask

  // release whoever holds the lock until no node owns or waits for it;
  // the pause lets the owner view catch up with the last transfer
  task automatic release_owners();
    int n;
    hold_off(1);
    while (busy_nodes != '0) begin
      n = 0;
      while (!busy_nodes[n]) n++;
      push_req(FUNC_RELEASE, node_t'(n));
      hold_off(1);
    end
  endtask

  // mostly releases by the current owner and acquires on any node, with some
  // arbitrary requests as noise. after a zero gap the owner view is one
  // transfer behind, so a release is not chosen twice in a row then
  task automatic random_phase(int count);
    int    i, gap, r, n;
    bit    fresh, last_rel;
    func_t f;
    last_rel = 1'b0;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      gap = idle_draw();
      hold_off(gap);
      fresh = (gap > 0);
      r = $urandom_range(0, 99);
      n = $urandom_range(0, NODES - 1);
      f = FUNC_ACQUIRE;
      if (r < 12) begin
        f = func_t'($urandom_range(0, 1));
      end else if (r < 58 && busy_nodes != '0 && (fresh || !last_rel)) begin
        f = FUNC_RELEASE;
        while (!busy_nodes[n]) n = $urandom_range(0, NODES - 1);
      end
      push_req(f, node_t'(n));
      last_rel = (f == FUNC_RELEASE);
    end
    quiet = 1'b0;
  endtask

  initial begin : stimulus
    req_if.valid <= 1'b0;
    req_if.func  <= FUNC_ACQUIRE;
    req_if.node  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed opening, visit limit at its reset value
    step_req(FUNC_RELEASE, 0);   // release with nobody holding the lock
    step_req(FUNC_ACQUIRE, 0);   // free lock, first global ticket granted
    step_req(FUNC_ACQUIRE, 0);   // local waiter behind the owner
    step_req(FUNC_ACQUIRE, 1);   // other node draws a global ticket and waits
    step_req(FUNC_RELEASE, 1);   // head still awaiting its global ticket
    step_req(FUNC_RELEASE, 0);   // handed on inside the cohort
    step_req(FUNC_RELEASE, 0);   // alone: back to global, node 1 granted
    step_req(FUNC_ACQUIRE, 2);
    step_req(FUNC_ACQUIRE, 3);
    step_req(FUNC_ACQUIRE, 1);
    step_req(FUNC_ACQUIRE, 1);
    step_req(FUNC_RELEASE, 3);   // waiter is not the owner
    step_req(FUNC_RELEASE, 1);
    step_req(FUNC_RELEASE, 1);
    step_req(FUNC_RELEASE, 1);   // alone: node 2 takes the global turn

    // limit of one: a single local handoff, then the lock goes back globally
    settle();
    write_limit(visit_t'(1));
    step_req(FUNC_ACQUIRE, 2);
    step_req(FUNC_ACQUIRE, 2);
    step_req(FUNC_ACQUIRE, 2);
    step_req(FUNC_RELEASE, 2);   // passes locally, one visit counted
    step_req(FUNC_RELEASE, 2);   // limit reached, node 3 granted, own head waits
    step_req(FUNC_RELEASE, 3);   // node 2 head granted again

    // a long run of local handoffs under the largest limit, back to back
    quiet = 1'b1;
    release_owners();
    settle();
    write_limit(VISIT_MAX);
    burst(FUNC_ACQUIRE, 0, 40);
    burst(FUNC_RELEASE, 0, 40);
    settle();
    quiet = 1'b0;

    // random traffic under a spread of limits, idle between settings
    write_limit('0);
    random_phase(290);
    settle();
    write_limit(visit_t'(2));
    random_phase(290);
    settle();
    write_limit(visit_t'(1));
    random_phase(290);
    settle();
    write_limit(VISIT_MAX);
    random_phase(290);
    settle();
    write_limit(visit_t'($urandom_range(3, 8)));
    random_phase(290);
    settle();
    write_limit(visit_t'($urandom_range(0, 1023)));
    random_phase(290);

    // drain and a short tail for anything unexpected
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_count == 0) begin
      $display("[cohort_ticket_lock_manager_top] OK");
    end else begin
      $display("[cohort_ticket_lock_manager_top] ERROR");
    end
    $finish;
  end

endmodule
